@@ design/xtcd_pkg.sv @@
package xtcd_pkg;

	localparam int RADIX_BYTES_DEF = 12;
	localparam int QUEUE_DEPTH     = 4;
	localparam int MAX_RESULTS     = 8;
	localparam logic [6:0] IDX_LO  = 7'd9;
	localparam logic [6:0] IDX_HI  = 7'd72;

	// configuration register indexes
	localparam logic [2:0] CFG_MIN_X      = 3'd0;
	localparam logic [2:0] CFG_MIN_Y      = 3'd1;
	localparam logic [2:0] CFG_MIN_Z      = 3'd2;
	localparam logic [2:0] CFG_MAX_X      = 3'd3;
	localparam logic [2:0] CFG_MAX_Y      = 3'd4;
	localparam logic [2:0] CFG_MAX_Z      = 3'd5;
	localparam logic [2:0] CFG_START_IDX  = 3'd6;
	localparam logic [2:0] CFG_ATOM_COUNT = 3'd7;

	typedef struct packed {
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
		logic [6:0]       start_idx;
		logic [23:0]      atom_count;
	} cfg_t;

	typedef struct packed {
		logic             ok;
		logic             radix;
		logic [6:0]       bits;
		logic [2:0][5:0]  w;
		logic [2:0][23:0] size;
	} geo_t;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] data_byte;
	} in_item_t;

	function automatic logic [24:0] magic_size(input logic [6:0] idx);
		logic [24:0] m;
		case (idx)
			7'd9:  m = 25'd8;
			7'd10: m = 25'd10;
			7'd11: m = 25'd12;
			7'd12: m = 25'd16;
			7'd13: m = 25'd20;
			7'd14: m = 25'd25;
			7'd15: m = 25'd32;
			7'd16: m = 25'd40;
			7'd17: m = 25'd50;
			7'd18: m = 25'd64;
			7'd19: m = 25'd80;
			7'd20: m = 25'd101;
			7'd21: m = 25'd128;
			7'd22: m = 25'd161;
			7'd23: m = 25'd203;
			7'd24: m = 25'd256;
			7'd25: m = 25'd322;
			7'd26: m = 25'd406;
			7'd27: m = 25'd512;
			7'd28: m = 25'd645;
			7'd29: m = 25'd812;
			7'd30: m = 25'd1024;
			7'd31: m = 25'd1290;
			7'd32: m = 25'd1625;
			7'd33: m = 25'd2048;
			7'd34: m = 25'd2580;
			7'd35: m = 25'd3250;
			7'd36: m = 25'd4096;
			7'd37: m = 25'd5060;
			7'd38: m = 25'd6501;
			7'd39: m = 25'd8192;
			7'd40: m = 25'd10321;
			7'd41: m = 25'd13003;
			7'd42: m = 25'd16384;
			7'd43: m = 25'd20642;
			7'd44: m = 25'd26007;
			7'd45: m = 25'd32768;
			7'd46: m = 25'd41285;
			7'd47: m = 25'd52015;
			7'd48: m = 25'd65536;
			7'd49: m = 25'd82570;
			7'd50: m = 25'd104031;
			7'd51: m = 25'd131072;
			7'd52: m = 25'd165140;
			7'd53: m = 25'd208063;
			7'd54: m = 25'd262144;
			7'd55: m = 25'd330280;
			7'd56: m = 25'd416127;
			7'd57: m = 25'd524287;
			7'd58: m = 25'd660561;
			7'd59: m = 25'd832255;
			7'd60: m = 25'd1048576;
			7'd61: m = 25'd1321122;
			7'd62: m = 25'd1664510;
			7'd63: m = 25'd2097152;
			7'd64: m = 25'd2642245;
			7'd65: m = 25'd3329021;
			7'd66: m = 25'd4194304;
			7'd67: m = 25'd5284491;
			7'd68: m = 25'd6658042;
			7'd69: m = 25'd8388607;
			7'd70: m = 25'd10568983;
			7'd71: m = 25'd13316085;
			7'd72: m = 25'd16777216;
			default: m = 25'd0;
		endcase
		return m;
	endfunction

endpackage

@@ design/xtc_coordinate_decompressor_unit.sv @@
// Compressed coordinate decoder, integer part.
// Input stream: one byte of the packed coordinate bit stream per transfer,
// tuser high on the first byte of a frame (restarts the decoder). Bytes go
// into a 4-entry queue, so the sender is held only while the queue is full.
// Output stream: one transfer per atom (at most 8 per byte); tlast on last atom.
// Config channel: register index and data; always ready. Writes to a min or max
// register start a geometry pass (product of axis sizes and its bit length),
// and bytes wait in the queue until it finishes.
// Per byte the decoder reads field chunks, flags and runs; each mixed-radix
// triple completed (k bytes of field, k <= 9) takes two bit-serial passes over
// its 8k field bits through the shared divider, which sets the rate.
// The output register holds a result until taken; while it is stalled the
// decoder stops at the next result and the queue keeps filling.
// Reset clears the decoder to the start of a frame and the registers to
// their defaults; no clearing pass is needed.
module xtc_coordinate_decompressor_unit
	import xtcd_pkg::*;
#(
	parameter int RADIX_BYTES = RADIX_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic         s_axis_tuser,   // frame_start
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata,   // coord_x, coord_y, coord_z, atom_number
	output logic         m_axis_tlast,   // last_atom
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cfg_t        cfg_q;
	geo_t        geo;
	in_item_t    s_item, q_item;
	logic        q_valid, q_pop, geo_restart;
	logic [31:0] ox, oy, oz;
	logic [23:0] oatom;

	assign cfg_ready   = 1'b1;
	assign geo_restart = cfg_valid && (cfg_index <= CFG_MAX_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lo         <= '0;
			cfg_q.hi         <= '0;
			cfg_q.start_idx  <= 7'd9;
			cfg_q.atom_count <= 24'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_X:      cfg_q.lo[0]      <= cfg_data;
				CFG_MIN_Y:      cfg_q.lo[1]      <= cfg_data;
				CFG_MIN_Z:      cfg_q.lo[2]      <= cfg_data;
				CFG_MAX_X:      cfg_q.hi[0]      <= cfg_data;
				CFG_MAX_Y:      cfg_q.hi[1]      <= cfg_data;
				CFG_MAX_Z:      cfg_q.hi[2]      <= cfg_data;
				CFG_START_IDX:  cfg_q.start_idx  <= cfg_data[6:0];
				CFG_ATOM_COUNT: cfg_q.atom_count <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign s_item.frame_start = s_axis_tuser;
	assign s_item.data_byte   = s_axis_tdata;

	xtcd_in_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_item  (s_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	xtcd_geometry u_geo (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.restart (geo_restart),
		.geo     (geo)
	);

	xtcd_back #(
		.RADIX_BYTES (RADIX_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.geo       (geo),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (ox),
		.out_y     (oy),
		.out_z     (oz),
		.out_atom  (oatom),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {oatom, oz, oy, ox};

endmodule

@@ design/xtcd_in_queue.sv @@
module xtcd_in_queue
	import xtcd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_valid,
	output logic     s_ready,
	input  in_item_t s_item,
	output logic     q_valid,
	input  logic     q_pop,
	output in_item_t q_item
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	in_item_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    cnt_q;
	logic           push, pop;

	assign s_ready = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_q];
	assign push    = s_valid && s_ready;
	assign pop     = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= s_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/xtcd_geometry.sv @@
module xtcd_geometry
	import xtcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic restart,
	output geo_t geo
);

	typedef enum logic [2:0] {G_SIZE, G_WID, G_M1, G_M2, G_M3, G_ADD, G_SCAN, G_DONE} gstate_t;

	gstate_t          st_q;
	logic [2:0][31:0] size_q;
	logic [2:0][5:0]  w_q;
	logic [47:0]      p_q, lo_q, hi_q;
	logic [71:0]      prod_q;
	logic [6:0]       scan_q, bits_q;
	logic             radix_q;

	function automatic logic [5:0] bitlen32(input logic [31:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) n = 6'(i + 1);
		end
		return n;
	endfunction

	always_comb begin
		geo.ok    = (st_q == G_DONE);
		geo.radix = radix_q;
		geo.bits  = bits_q;
		geo.w     = w_q;
		for (int i = 0; i < 3; i++) geo.size[i] = size_q[i][23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= G_SIZE;
			radix_q <= 1'b0;
			bits_q  <= '0;
			w_q     <= '0;
		end else if (restart) begin
			st_q <= G_SIZE;
		end else begin
			unique case (st_q)
				G_SIZE: begin
					for (int i = 0; i < 3; i++) size_q[i] <= cfg.hi[i] - cfg.lo[i] + 32'd1;
					st_q <= G_WID;
				end
				G_WID: begin
					radix_q <= 1'b0;
					bits_q  <= '0;
					if ((size_q[0][31:24] | size_q[1][31:24] | size_q[2][31:24]) != '0) begin
						for (int i = 0; i < 3; i++) w_q[i] <= bitlen32(size_q[i]);
						st_q <= G_DONE;
					end else begin
						w_q  <= '0;
						st_q <= G_M1;
					end
				end
				G_M1: begin
					p_q  <= size_q[0][23:0] * size_q[1][23:0];
					st_q <= G_M2;
				end
				G_M2: begin
					lo_q <= p_q[23:0] * size_q[2][23:0];
					st_q <= G_M3;
				end
				G_M3: begin
					hi_q <= p_q[47:24] * size_q[2][23:0];
					st_q <= G_ADD;
				end
				G_ADD: begin
					prod_q <= {hi_q, 24'd0} + {24'd0, lo_q};
					scan_q <= 7'd72;
					st_q   <= G_SCAN;
				end
				G_SCAN: begin
					// leading one search, one bit per cycle
					if (scan_q == '0 || prod_q[71]) begin
						bits_q  <= scan_q;
						radix_q <= (scan_q != '0);
						st_q    <= G_DONE;
					end else begin
						prod_q <= {prod_q[70:0], 1'b0};
						scan_q <= scan_q - 7'd1;
					end
				end
				G_DONE: st_q <= G_DONE;
				default: st_q <= G_SIZE;
			endcase
		end
	end

endmodule

@@ design/xtcd_back.sv @@
module xtcd_back
	import xtcd_pkg::*;
#(
	parameter int RADIX_BYTES = RADIX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  geo_t        geo,
	input  logic        q_valid,
	input  in_item_t    q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [23:0] out_atom,
	output logic        out_last
);

	localparam int RB_IW = $clog2(RADIX_BYTES);
	localparam logic [1:0] ADJ_DOWN = 2'd0;
	localparam logic [1:0] ADJ_HOLD = 2'd1;
	localparam logic [1:0] ADJ_UP   = 2'd2;

	typedef enum logic [3:0] {
		ST_GET, ST_RUN, ST_DEC, ST_EMIT_F, ST_AFTF, ST_DIV, ST_DFIN,
		ST_EMIT_S, ST_EMIT_P, ST_SUPD, ST_END
	} state_t;

	typedef enum logic [2:0] {PH_LARGE, PH_FLAG, PH_RUN, PH_SMALL, PH_IDLE} phase_t;

	state_t           st_q;
	phase_t           phase_q;
	logic [15:0]      win_q;
	logic [4:0]       left_q;
	logic [7:0]       rb_q [RADIX_BYTES];
	logic [2:0][31:0] prev_q, s_q;
	logic [6:0]       sidx_q;
	logic [23:0]      shalf_q, sshalf_q;
	logic [4:0]       run_left_q, run_done_q;
	logic [1:0]       adj_q;
	logic [23:0]      done_q;
	logic [3:0]       n_q;
	logic             open_q;
	logic [1:0]       axis_q;
	logic [6:0]       fbits_q, got_q;
	logic [3:0]       chunk_q;
	logic [31:0]      acc_q;
	logic [6:0]       pos_q;
	logic [24:0]      r_q, dv_q, val2_q;
	logic             pass_q;

	// comb
	logic [6:0]       rem;
	logic [3:0]       ft, pull_n;
	logic             can_pull;
	logic [4:0]       new_left;
	logic [7:0]       pull_v;
	logic [4:0]       v5;
	logic [8:0]       q3;
	logic [4:0]       run3;
	logic [1:0]       m3;
	logic [3:0]       kbytes;
	logic [7:0]       pos_full;
	logic [6:0]       pos_top;
	logic             dbit, ge;
	logic [25:0]      rr;
	logic [24:0]      rnext;
	logic [31:0]      val0;
	logic [6:0]       ci;
	logic [23:0]      init_half, init_shalf;
	logic [6:0]       ad_idx;
	logic [23:0]      ad_half, ad_shalf;
	logic [24:0]      small_dv;
	logic [24:0]      dv_hi, dv_mid;
	logic             emit_slot;
	logic [2:0][31:0] emit_c;
	logic [1:0]       axis_n;
	logic             fs;
	phase_t           eff_phase;
	logic [23:0]      eff_done;
	logic [7:0]       eff_win;
	logic [4:0]       eff_left;

	assign out_valid = (st_q == ST_GET) ? out_valid_int : out_valid_int;
	logic out_valid_int;

	always_comb begin
		rem = fbits_q - got_q;
		ft  = (rem > 7'd8) ? 4'd8 : rem[3:0];
		unique case (phase_q)
			PH_FLAG: pull_n = 4'd1;
			PH_RUN:  pull_n = 4'd5;
			default: pull_n = ft;
		endcase
		can_pull = ({1'b0, pull_n} <= left_q);
		new_left = left_q - {1'b0, pull_n};
		pull_v   = 8'((win_q >> new_left) & ((16'd1 << pull_n) - 16'd1));

		// v mod 3 by reciprocal: floor(v/3) = (v*11)>>5 for v < 32
		v5   = pull_v[4:0];
		q3   = (9'(v5) * 9'd11) >> 5;
		run3 = 5'(q3 * 9'd3);
		m3   = 2'(v5 - run3);

		kbytes   = 4'((fbits_q + 7'd7) >> 3);
		pos_full = {1'b0, kbytes, 3'b000} - 8'd1;
		pos_top  = pos_full[6:0];

		dbit  = rb_q[RB_IW'(pos_q[6:3])][pos_q[2:0]];
		rr    = {r_q, dbit};
		ge    = (rr >= {1'b0, dv_q});
		rnext = ge ? 25'(rr - {1'b0, dv_q}) : rr[24:0];

		for (int j = 0; j < 4; j++) begin
			val0[j*8 +: 8] = (4'(j) < kbytes) ? rb_q[j] : 8'd0;
		end

		if (cfg.start_idx < IDX_LO) ci = IDX_LO;
		else if (cfg.start_idx > IDX_HI) ci = IDX_HI;
		else ci = cfg.start_idx;
		init_half  = 24'(magic_size(ci) >> 1);
		init_shalf = 24'(magic_size((ci == IDX_LO) ? IDX_LO : ci - 7'd1) >> 1);

		ad_idx   = sidx_q;
		ad_half  = shalf_q;
		ad_shalf = sshalf_q;
		if (adj_q == ADJ_DOWN && sidx_q > IDX_LO) begin
			ad_idx   = sidx_q - 7'd1;
			ad_half  = sshalf_q;
			ad_shalf = (sidx_q - 7'd1 > IDX_LO) ? 24'(magic_size(sidx_q - 7'd2) >> 1) : 24'd0;
		end else if (adj_q == ADJ_UP && sidx_q < IDX_HI) begin
			ad_idx   = sidx_q + 7'd1;
			ad_shalf = shalf_q;
			ad_half  = 24'(magic_size(sidx_q + 7'd1) >> 1);
		end

		small_dv = magic_size(sidx_q);
		dv_hi    = {1'b0, (geo.size[2] == '0) ? 24'd1 : geo.size[2]};
		dv_mid   = {1'b0, (geo.size[1] == '0) ? 24'd1 : geo.size[1]};

		emit_slot = !out_valid_int || out_ready;
		emit_c    = (st_q == ST_EMIT_S) ? s_q : prev_q;
		axis_n    = axis_q + 2'd1;

		fs        = q_item.frame_start;
		eff_phase = fs ? ((cfg.atom_count != '0) ? PH_LARGE : PH_IDLE) : phase_q;
		eff_done  = fs ? 24'd0 : done_q;
		eff_win   = fs ? 8'd0 : win_q[7:0];
		eff_left  = fs ? 5'd0 : left_q;
	end

	assign q_pop = (st_q == ST_GET) && q_valid && geo.ok;

	always_ff @(posedge clk) begin
		if (st_q == ST_RUN && (phase_q == PH_LARGE || phase_q == PH_SMALL) && open_q
				&& got_q < fbits_q && can_pull) begin
			rb_q[RB_IW'(chunk_q)] <= pull_v;
		end else if (st_q == ST_DIV) begin
			rb_q[RB_IW'(pos_q[6:3])][pos_q[2:0]] <= ge;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_GET;
			phase_q       <= PH_LARGE;
			win_q         <= '0;
			left_q        <= '0;
			prev_q        <= '0;
			s_q           <= '0;
			sidx_q        <= IDX_LO;
			shalf_q       <= '0;
			sshalf_q      <= '0;
			run_left_q    <= '0;
			run_done_q    <= '0;
			adj_q         <= ADJ_HOLD;
			done_q        <= '0;
			n_q           <= '0;
			open_q        <= 1'b0;
			axis_q        <= '0;
			fbits_q       <= '0;
			got_q         <= '0;
			chunk_q       <= '0;
			acc_q         <= '0;
			pos_q         <= '0;
			r_q           <= '0;
			dv_q          <= '0;
			val2_q        <= '0;
			pass_q        <= 1'b0;
			out_valid_int <= 1'b0;
			out_x         <= '0;
			out_y         <= '0;
			out_z         <= '0;
			out_atom      <= '0;
			out_last      <= 1'b0;
		end else begin
			if (out_ready) out_valid_int <= 1'b0;

			unique case (st_q)
				ST_GET: begin
					if (q_valid && geo.ok) begin
						if (fs) begin
							sidx_q     <= ci;
							shalf_q    <= init_half;
							sshalf_q   <= init_shalf;
							prev_q     <= '0;
							run_left_q <= '0;
							run_done_q <= '0;
							done_q     <= '0;
							adj_q      <= ADJ_HOLD;
							open_q     <= 1'b0;
							axis_q     <= '0;
							fbits_q    <= '0;
							got_q      <= '0;
							chunk_q    <= '0;
							acc_q      <= '0;
						end
						if (eff_phase == PH_IDLE || eff_done >= cfg.atom_count) begin
							phase_q <= PH_IDLE;
							win_q   <= '0;
							left_q  <= '0;
						end else begin
							phase_q <= eff_phase;
							win_q   <= {eff_win, q_item.data_byte};
							left_q  <= eff_left + 5'd8;
							n_q     <= '0;
							st_q    <= ST_RUN;
						end
					end
				end

				ST_RUN: begin
					unique case (phase_q)
						PH_LARGE, PH_SMALL: begin
							if (!open_q) begin
								open_q  <= 1'b1;
								axis_q  <= '0;
								got_q   <= '0;
								chunk_q <= '0;
								acc_q   <= '0;
								if (phase_q == PH_SMALL) fbits_q <= sidx_q;
								else if (geo.radix) fbits_q <= geo.bits;
								else fbits_q <= {1'b0, geo.w[0]};
							end else if (got_q < fbits_q) begin
								if (!can_pull) begin
									st_q <= ST_END;
								end else begin
									left_q  <= new_left;
									chunk_q <= chunk_q + 4'd1;
									acc_q   <= (acc_q << ft) | {24'd0, pull_v};
									got_q   <= got_q + {3'd0, ft};
								end
							end else if (phase_q == PH_SMALL || geo.radix) begin
								pass_q <= 1'b0;
								pos_q  <= pos_top;
								r_q    <= '0;
								dv_q   <= (phase_q == PH_SMALL) ? small_dv : dv_hi;
								st_q   <= ST_DIV;
							end else begin
								prev_q[axis_q] <= acc_q + cfg.lo[axis_q];
								if (axis_q == 2'd2) begin
									open_q  <= 1'b0;
									phase_q <= PH_FLAG;
								end else begin
									axis_q  <= axis_n;
									fbits_q <= {1'b0, geo.w[axis_n]};
									got_q   <= '0;
									chunk_q <= '0;
									acc_q   <= '0;
								end
							end
						end
						PH_FLAG: begin
							if (!can_pull) begin
								st_q <= ST_END;
							end else begin
								left_q <= new_left;
								adj_q  <= ADJ_HOLD;
								if (pull_v[0]) phase_q <= PH_RUN;
								else st_q <= ST_DEC;
							end
						end
						PH_RUN: begin
							if (!can_pull) begin
								st_q <= ST_END;
							end else begin
								left_q     <= new_left;
								adj_q      <= m3;   // remainder 0/1/2 maps to down/hold/up
								run_left_q <= run3;
								st_q       <= ST_DEC;
							end
						end
						default: st_q <= ST_END;
					endcase
				end

				ST_DEC: begin
					if (run_left_q != '0) begin
						run_done_q <= '0;
						open_q     <= 1'b0;
						phase_q    <= PH_SMALL;
						st_q       <= ST_RUN;
					end else begin
						st_q <= ST_EMIT_F;
					end
				end

				ST_EMIT_F, ST_EMIT_S, ST_EMIT_P: begin
					if (emit_slot) begin
						if (done_q >= cfg.atom_count) begin
							phase_q <= PH_IDLE;
						end else begin
							if (n_q < 4'(MAX_RESULTS)) begin
								out_valid_int <= 1'b1;
								out_x         <= emit_c[0];
								out_y         <= emit_c[1];
								out_z         <= emit_c[2];
								out_atom      <= done_q;
								out_last      <= ({1'b0, done_q} + 25'd1 >= {1'b0, cfg.atom_count});
								n_q           <= n_q + 4'd1;
							end
							done_q <= done_q + 24'd1;
							if ({1'b0, done_q} + 25'd1 >= {1'b0, cfg.atom_count}) phase_q <= PH_IDLE;
						end
						if (st_q == ST_EMIT_F) st_q <= ST_AFTF;
						else if (st_q == ST_EMIT_S && run_done_q == '0) st_q <= ST_EMIT_P;
						else st_q <= ST_SUPD;
					end
				end

				ST_AFTF: begin
					if (phase_q == PH_IDLE) begin
						st_q <= ST_END;
					end else begin
						sidx_q   <= ad_idx;
						shalf_q  <= ad_half;
						sshalf_q <= ad_shalf;
						adj_q    <= ADJ_HOLD;
						phase_q  <= PH_LARGE;
						st_q     <= ST_RUN;
					end
				end

				ST_DIV: begin
					// restoring division, one dividend bit per cycle, quotient in place
					r_q <= rnext;
					if (pos_q == '0) begin
						if (!pass_q) begin
							val2_q <= rnext;
							pass_q <= 1'b1;
							pos_q  <= pos_top;
							r_q    <= '0;
							dv_q   <= (phase_q == PH_SMALL) ? small_dv : dv_mid;
						end else begin
							st_q <= ST_DFIN;
						end
					end else begin
						pos_q <= pos_q - 7'd1;
					end
				end

				ST_DFIN: begin
					open_q <= 1'b0;
					if (phase_q == PH_SMALL) begin
						s_q[0] <= val0 + prev_q[0] - {8'd0, shalf_q};
						s_q[1] <= {7'd0, r_q} + prev_q[1] - {8'd0, shalf_q};
						s_q[2] <= {7'd0, val2_q} + prev_q[2] - {8'd0, shalf_q};
						st_q   <= ST_EMIT_S;
					end else begin
						prev_q[0] <= val0 + cfg.lo[0];
						prev_q[1] <= {7'd0, r_q} + cfg.lo[1];
						prev_q[2] <= {7'd0, val2_q} + cfg.lo[2];
						phase_q   <= PH_FLAG;
						st_q      <= ST_RUN;
					end
				end

				ST_SUPD: begin
					prev_q     <= s_q;
					run_done_q <= run_done_q + 5'd3;
					if (phase_q == PH_IDLE) begin
						st_q <= ST_END;
					end else begin
						if ({1'b0, run_done_q} + 6'd3 >= {1'b0, run_left_q}) begin
							sidx_q   <= ad_idx;
							shalf_q  <= ad_half;
							sshalf_q <= ad_shalf;
							adj_q    <= ADJ_HOLD;
							phase_q  <= PH_LARGE;
						end
						st_q <= ST_RUN;
					end
				end

				ST_END: begin
					if (phase_q == PH_IDLE) begin
						win_q  <= '0;
						left_q <= '0;
					end
					st_q <= ST_GET;
				end

				default: st_q <= ST_GET;
			endcase
		end
	end

endmodule
